FILE: hw/rtl/szpd_pkg.sv
`default_nettype none
package szpd_pkg;

    // Register indexes of the configuration port
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_INFLUENCE = 1'b1;

    localparam logic [7:0] THRESHOLD_RST = 8'd48;
    localparam logic [8:0] INFLUENCE_RST = 9'd128;
    localparam logic [8:0] INFLUENCE_MAX = 9'd256;

    // One strobe per datapath step, issued by the controller
    typedef struct packed {
        logic load;
        logic calc_d;
        logic calc_v;
        logic mul_lo;
        logic mul_hi;
        logic sum_rhs;
        logic decide;
        logic square;
        logic commit;
    } t_cmd;

endpackage
`default_nettype wire

FILE: hw/rtl/szpd_ram.sv
`default_nettype none
module szpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/szpd_cfg.sv
`default_nettype none
module szpd_cfg
    import szpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [7:0]  o_threshold,
    output logic      [8:0]  o_influence
);
    logic [7:0] r_threshold;
    logic [8:0] r_influence;
    logic       wr_en;

    assign pready      = 1'b1;
    assign wr_en       = psel & penable & pwrite;
    assign o_threshold = r_threshold;
    assign o_influence = r_influence;

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_influence <= INFLUENCE_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_THRESHOLD: r_threshold <= pwdata[7:0];
                REG_INFLUENCE: r_influence <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            REG_THRESHOLD: prdata = {24'd0, r_threshold};
            REG_INFLUENCE: prdata = {23'd0, r_influence};
            default:       prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

FILE: hw/rtl/szpd_ctrl.sv
`default_nettype none
module szpd_ctrl
    import szpd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cmd      o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_CALC_D, S_CALC_V, S_MUL_LO, S_MUL_HI,
        S_SUM_RHS, S_DECIDE, S_SQUARE, S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_valid;
    assign out_free = !r_valid || i_ready;

    // Decode state into datapath strobes
    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = (r_state == S_IDLE) && i_valid;
        o_cmd.calc_d  = (r_state == S_CALC_D);
        o_cmd.calc_v  = (r_state == S_CALC_V);
        o_cmd.mul_lo  = (r_state == S_MUL_LO);
        o_cmd.mul_hi  = (r_state == S_MUL_HI);
        o_cmd.sum_rhs = (r_state == S_SUM_RHS);
        o_cmd.decide  = (r_state == S_DECIDE);
        o_cmd.square  = (r_state == S_SQUARE);
        o_cmd.commit  = (r_state == S_COMMIT) && out_free;
    end

    // Advance through the steps; hold in commit until the output slot frees
    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_ready;
        unique case (r_state)
            S_IDLE:    if (i_valid) n_state = S_CALC_D;
            S_CALC_D:  n_state = S_CALC_V;
            S_CALC_V:  n_state = S_MUL_LO;
            S_MUL_LO:  n_state = S_MUL_HI;
            S_MUL_HI:  n_state = S_SUM_RHS;
            S_SUM_RHS: n_state = S_DECIDE;
            S_DECIDE:  n_state = S_SQUARE;
            S_SQUARE:  n_state = S_COMMIT;
            S_COMMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/szpd_dpath.sv
`default_nettype none
module szpd_dpath
    import szpd_pkg::*;
#(
    parameter int LAG = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic signed [15:0] i_sample,
    input  wire logic        [7:0]  i_threshold,
    input  wire logic        [8:0]  i_influence,
    output logic                    o_is_peak,
    output logic                    o_window_full,
    output logic signed      [15:0] o_stored_value
);
    localparam int L   = $clog2(LAG);
    localparam int AW  = (L < 1) ? 1 : L;
    localparam int SW  = 16 + L;
    localparam int QW  = 31 + L;
    localparam int DW  = 17 + L;
    localparam int VW  = 31 + 2 * L;
    localparam int H   = (VW + 1) / 2;
    localparam int RW  = 16 + VW;
    localparam int LW  = 2 * DW + 8;
    localparam int CW  = (LW > RW) ? LW : RW;
    localparam logic signed [DW-1:0] LAG_D = DW'(LAG);
    localparam logic        [VW-1:0] LAG_V = VW'(LAG);
    localparam logic        [L:0]    LAG_F = (L + 1)'(LAG);
    localparam logic        [AW-1:0] LAST_SLOT = AW'(LAG - 1);

    // Window state
    logic        [AW-1:0]   r_slot;
    logic        [L:0]      r_fill;
    logic signed [SW-1:0]   r_sum;
    logic        [QW-1:0]   r_sumsq;
    logic signed [15:0]     r_newest;

    // Per-item working registers
    logic signed [15:0]     r_x;
    logic                   r_full;
    logic signed [DW-1:0]   r_d;
    logic signed [2*SW-1:0] r_s2;
    logic signed [25:0]     r_px;
    logic signed [25:0]     r_pl;
    logic        [VW-1:0]   r_var;
    logic signed [2*DW-1:0] r_dd;
    logic signed [15:0]     r_damp;
    logic        [15:0]     r_thr2;
    logic        [16+H-1:0] r_plo;
    logic        [16+VW-H-1:0] r_phi;
    logic signed [15:0]     r_old;
    logic        [31:0]     r_oldsq;
    logic        [RW-1:0]   r_rhs;
    logic                   r_peak;
    logic signed [15:0]     r_stored;
    logic        [31:0]     r_stsq;

    logic signed [15:0]     ram_rdata;
    logic        [8:0]      weight;
    logic signed [25:0]     damp_sum;
    logic        [CW-1:0]   lhs;
    logic        [CW-1:0]   rhs;
    logic                   peak;

    szpd_ram #(
        .WIDTH(16),
        .DEPTH(1 << AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.commit),
        .i_waddr(r_slot),
        .i_wdata(r_stored),
        .i_raddr(r_slot),
        .o_rdata(ram_rdata)
    );

    assign weight   = (i_influence > INFLUENCE_MAX) ? INFLUENCE_MAX : i_influence;
    assign damp_sum = r_px + r_pl + 26'sd128;
    assign lhs      = CW'({r_dd, 8'd0});
    assign rhs      = CW'(r_rhs);
    assign peak     = r_full && (r_d > 0) && (lhs > rhs);

    // Step registers, each loaded by the strobe of its step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_sample;
            r_full <= (r_fill == LAG_F);
        end
        if (i_cmd.calc_d) begin
            r_d    <= DW'(r_x) * LAG_D - DW'(r_sum);
            r_s2   <= r_sum * r_sum;
            r_px   <= 26'($signed({1'b0, weight}) * r_x);
            r_pl   <= 26'($signed({1'b0, 9'(INFLUENCE_MAX - weight)}) * r_newest);
            r_thr2 <= i_threshold * i_threshold;
        end
        if (i_cmd.calc_v) begin
            r_var  <= VW'(r_sumsq) * LAG_V - VW'(r_s2);
            r_dd   <= r_d * r_d;
            r_damp <= 16'(damp_sum >>> 8);
        end
        if (i_cmd.mul_lo) begin
            r_plo  <= (16 + H)'(r_thr2 * r_var[H-1:0]);
            r_old  <= r_full ? ram_rdata : 16'sd0;
        end
        if (i_cmd.mul_hi) begin
            r_phi   <= (16 + VW - H)'(r_thr2 * r_var[VW-1:H]);
            r_oldsq <= 32'(r_old * r_old);
        end
        if (i_cmd.sum_rhs) begin
            r_rhs <= (RW'(r_phi) << H) + RW'(r_plo);
        end
        if (i_cmd.decide) begin
            r_peak   <= peak;
            r_stored <= peak ? r_damp : r_x;
        end
        if (i_cmd.square) begin
            r_stsq <= 32'(r_stored * r_stored);
        end
    end

    // Commit the stored value into the window and load the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_fill   <= '0;
            r_sum    <= '0;
            r_sumsq  <= '0;
            r_newest <= '0;
        end else if (i_cmd.commit) begin
            r_slot   <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            if (r_fill != LAG_F) begin
                r_fill <= r_fill + 1'b1;
            end
            r_sum    <= r_sum - SW'(r_old) + SW'(r_stored);
            r_sumsq  <= r_sumsq - QW'(r_oldsq) + QW'(r_stsq);
            r_newest <= r_stored;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_is_peak      <= r_peak;
            o_window_full  <= r_full;
            o_stored_value <= r_stored;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/smoothed_zscore_peak_detector_top.sv
`default_nettype none
// Smoothed z-score peak detector. Each sample transaction is checked against the
// mean and population deviation of the last LAG stored values; a sample more than
// threshold/16 deviations above the mean is flagged and stored damped by influence.
// Until LAG values are stored no peak is flagged. The controller steps a single
// datapath through its multiply stages one after another, and the next sample is
// taken once the result is in the output register, so a new sample is not accepted
// before the last one is through.
// A result still waiting in the output register holds the final step.
// Window memory needs no clearing pass.
module smoothed_zscore_peak_detector_top
    import szpd_pkg::*;
#(
    parameter int LAG = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_sample,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_is_peak,
    output logic                    o_window_full,
    output logic signed      [15:0] o_stored_value,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [2:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);
    t_cmd       cmd;
    logic [7:0] threshold;
    logic [8:0] influence;

    szpd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_threshold(threshold),
        .o_influence(influence)
    );

    szpd_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_cmd  (cmd)
    );

    szpd_dpath #(
        .LAG(LAG)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_sample      (i_sample),
        .i_threshold   (threshold),
        .i_influence   (influence),
        .o_is_peak     (o_is_peak),
        .o_window_full (o_window_full),
        .o_stored_value(o_stored_value)
    );
endmodule
`default_nettype wire
